FILE: rtl/sgag_pkg.sv
`default_nettype none

package sgag_pkg;

  // view geometry
  localparam int NDIM     = 3;
  localparam int MAX_DIMS = 3;

  // datapath widths
  localparam int ADDR_BITS  = 48;
  localparam int OUT_W      = 48;
  localparam int IDX_W      = 16;
  localparam int STRIDE_W   = 32;
  localparam int BASE_W     = 32;
  localparam int EB_W       = 4;
  localparam int PROD_W     = IDX_W + STRIDE_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_OFFSET   = 8'd0,
    REG_ELEM_BYTES    = 8'd1,
    REG_EXTENT_OUTER  = 8'd2,
    REG_EXTENT_MIDDLE = 8'd3,
    REG_EXTENT_INNER  = 8'd4,
    REG_STRIDE_OUTER  = 8'd5,
    REG_STRIDE_MIDDLE = 8'd6,
    REG_STRIDE_INNER  = 8'd7
  } cfg_reg_t;

  // dimension slots, outer first
  localparam int DIM_OUTER  = 0;
  localparam int DIM_MIDDLE = 1;
  localparam int DIM_INNER  = 2;

  localparam logic [BASE_W-1:0]   RST_BASE       = '0;
  localparam logic [EB_W-1:0]     RST_ELEM_BYTES = EB_W'(4);
  localparam logic [IDX_W-1:0]    RST_EXTENT     = IDX_W'(1);
  localparam logic [STRIDE_W-1:0] RST_STRIDE     = STRIDE_W'(1);

  typedef struct packed {
    logic [BASE_W-1:0]              base;
    logic [EB_W-1:0]                elem_bytes;
    logic [NDIM-1:0][IDX_W-1:0]     extent;
    logic [NDIM-1:0][STRIDE_W-1:0]  stride;
  } cfg_t;

  // one issued element, leaving the odometer
  typedef struct packed {
    logic                        vld;
    logic [NDIM-1:0][IDX_W-1:0]  idx;
    logic [ADDR_BITS-1:0]        count;
    logic                        last;
  } issue_t;

  // only the innermost MAX_DIMS dimensions are walked
  function automatic logic dim_active(input int d);
    return d >= (NDIM - MAX_DIMS);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sgag_ifs.sv
`default_nettype none

interface sgag_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface sgag_out_if import sgag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] src_byte_addr;
  logic [OUT_W-1:0] dst_byte_addr;
  logic             last;
  modport source (output valid, output src_byte_addr, output dst_byte_addr, output last,
                  input ready);
  modport sink   (input valid, input src_byte_addr, input dst_byte_addr, input last,
                  output ready);
endinterface

interface sgag_cfg_if import sgag_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sgag_cfg_regs.sv
`default_nettype none

module sgag_cfg_regs import sgag_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_BASE_OFFSET:   cfg_nxt.base                  = BASE_W'(wr_data);
        REG_ELEM_BYTES:    cfg_nxt.elem_bytes            = EB_W'(wr_data);
        REG_EXTENT_OUTER:  cfg_nxt.extent[DIM_OUTER]     = IDX_W'(wr_data);
        REG_EXTENT_MIDDLE: cfg_nxt.extent[DIM_MIDDLE]    = IDX_W'(wr_data);
        REG_EXTENT_INNER:  cfg_nxt.extent[DIM_INNER]     = IDX_W'(wr_data);
        REG_STRIDE_OUTER:  cfg_nxt.stride[DIM_OUTER]     = STRIDE_W'(wr_data);
        REG_STRIDE_MIDDLE: cfg_nxt.stride[DIM_MIDDLE]    = STRIDE_W'(wr_data);
        REG_STRIDE_INNER:  cfg_nxt.stride[DIM_INNER]     = STRIDE_W'(wr_data);
        default:           cfg_nxt = cfg_r;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base       <= RST_BASE;
      cfg_r.elem_bytes <= RST_ELEM_BYTES;
      for (int d = 0; d < NDIM; d++) begin
        cfg_r.extent[d] <= RST_EXTENT;
        cfg_r.stride[d] <= RST_STRIDE;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/sgag_odometer.sv
`default_nettype none

module sgag_odometer import sgag_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        take,
  input  wire logic                        restart,
  input  wire logic [NDIM-1:0][IDX_W-1:0]  extent,
  output issue_t                           issue
);

  logic [NDIM-1:0][IDX_W-1:0] dim_index_r, dim_index_nxt;
  logic [ADDR_BITS-1:0]       count_r, count_nxt;
  issue_t                     issue_r, issue_nxt;

  logic [NDIM-1:0][IDX_W-1:0] idx_cur;
  logic [ADDR_BITS-1:0]       count_cur;
  logic [NDIM-1:0][IDX_W-1:0] eff_ext;
  logic [NDIM-1:0]            at_end;
  logic                       last;
  logic                       carry;

  always_comb begin
    idx_cur   = restart ? '0 : dim_index_r;
    count_cur = restart ? '0 : count_r;

    // zero extent and unused dimensions count as extent one
    for (int d = 0; d < NDIM; d++) begin
      eff_ext[d] = (!dim_active(d) || (extent[d] == '0)) ? IDX_W'(1) : extent[d];
      at_end[d]  = ((IDX_W+1)'(idx_cur[d]) + (IDX_W+1)'(1)) >= (IDX_W+1)'(eff_ext[d]);
    end
    last = &at_end;

    // innermost digit first; an overrun digit wraps like one at its end
    carry         = 1'b1;
    dim_index_nxt = idx_cur;
    for (int d = NDIM - 1; d >= 0; d--) begin
      if (carry) begin
        if (!at_end[d]) begin
          dim_index_nxt[d] = idx_cur[d] + IDX_W'(1);
          carry            = 1'b0;
        end else begin
          dim_index_nxt[d] = '0;
        end
      end
    end
    count_nxt = last ? '0 : count_cur + ADDR_BITS'(1);

    issue_nxt.vld   = take;
    issue_nxt.idx   = idx_cur;
    issue_nxt.count = count_cur;
    issue_nxt.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_index_r <= '0;
      count_r     <= '0;
    end else if (take) begin
      dim_index_r <= dim_index_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r.vld <= 1'b0;
    end else if (adv) begin
      issue_r <= issue_nxt;
    end
  end

  assign issue = issue_r;

endmodule

`default_nettype wire

FILE: rtl/sgag_addr_pipe.sv
`default_nettype none

module sgag_addr_pipe import sgag_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  issue_t                 issue,
  input  wire logic              out_ready,
  output logic                   adv,
  output logic                   out_valid,
  output logic [OUT_W-1:0]       src_byte_addr,
  output logic [OUT_W-1:0]       dst_byte_addr,
  output logic                   out_last
);

  // stage 2: index * stride products, packed count * size
  logic                            s2_vld_r;
  logic [NDIM-1:0][ADDR_BITS-1:0]  s2_prod_r;
  logic [ADDR_BITS-1:0]            s2_dst_r;
  logic                            s2_last_r;
  logic [NDIM-1:0][PROD_W-1:0]     prod;
  logic [ADDR_BITS+EB_W-1:0]       dst_full;

  // stage 3: source element position
  logic                            s3_vld_r;
  logic [ADDR_BITS-1:0]            s3_pos_r;
  logic [ADDR_BITS-1:0]            s3_dst_r;
  logic                            s3_last_r;
  logic [ADDR_BITS-1:0]            pos_nxt;

  // stage 4: output register
  logic                            out_vld_r;
  logic [OUT_W-1:0]                src_r;
  logic [OUT_W-1:0]                dst_r;
  logic                            last_r;
  logic [ADDR_BITS+EB_W-1:0]       src_full;

  // whole pipe moves together unless the result is held
  assign adv = !out_vld_r || out_ready;

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      prod[d] = dim_active(d) ? PROD_W'(issue.idx[d]) * PROD_W'(cfg.stride[d]) : '0;
    end
    dst_full = issue.count * cfg.elem_bytes;

    pos_nxt = ADDR_BITS'(cfg.base);
    for (int d = 0; d < NDIM; d++) begin
      pos_nxt = pos_nxt + s2_prod_r[d];
    end

    src_full = s3_pos_r * cfg.elem_bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r  <= issue.vld;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < NDIM; d++) begin
        s2_prod_r[d] <= ADDR_BITS'(prod[d]);
      end
      s2_dst_r  <= dst_full[ADDR_BITS-1:0];
      s2_last_r <= issue.last;

      s3_pos_r  <= pos_nxt;
      s3_dst_r  <= s2_dst_r;
      s3_last_r <= s2_last_r;

      src_r     <= OUT_W'(src_full[ADDR_BITS-1:0]);
      dst_r     <= OUT_W'(s3_dst_r);
      last_r    <= s3_last_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign src_byte_addr = src_r;
  assign dst_byte_addr = dst_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

FILE: rtl/strided_gather_address_generator.sv
// Strided gather address generator. Each input item either restarts the walk
// (restart=1) or asks for the next element (restart=0) of a three-dimensional
// strided view, walked outer/middle/inner with the inner index fastest. Each
// item yields one result: the source byte address
// (base + sum(index*stride)) * elem_bytes, the packed destination byte address
// count * elem_bytes, and last on the final element, after which the walk
// wraps to the first. Addresses wrap modulo 2^48. One item is taken every
// cycle while the result channel is not stalled; each result passes through
// the four registers of the pipe (odometer, index*stride multipliers,
// position adder, size multiplier) in that order. Back-pressure on the
// result channel freezes the whole pipe. Registers are written through the
// cfg channel, which is always ready; write them only while no item is in
// flight. Unmapped register indexes are dropped. No clearing pass after reset.

`default_nettype none

module strided_gather_address_generator import sgag_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sgag_in_if.sink     in_ch,
  sgag_out_if.source  out_ch,
  sgag_cfg_if.sink    cfg_ch
);

  cfg_t   cfg;
  issue_t issue;
  logic   adv;
  logic   take;

  // config writes never stall
  assign cfg_ch.ready = 1'b1;

  sgag_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  // an item enters whenever the pipe moves
  assign in_ch.ready = adv;
  assign take        = in_ch.valid && adv;

  sgag_odometer u_odometer (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .take    (take),
    .restart (in_ch.restart),
    .extent  (cfg.extent),
    .issue   (issue)
  );

  sgag_addr_pipe u_addr_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .issue         (issue),
    .out_ready     (out_ch.ready),
    .adv           (adv),
    .out_valid     (out_ch.valid),
    .src_byte_addr (out_ch.src_byte_addr),
    .dst_byte_addr (out_ch.dst_byte_addr),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire

FILE: rtl/sgag_checker.sv
`default_nettype none

module sgag_checker import sgag_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] src_byte_addr,
  input wire logic [OUT_W-1:0] dst_byte_addr,
  input wire logic             out_last,
  input wire logic             cfg_ready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(src_byte_addr)
                                && $stable(dst_byte_addr) && $stable(out_last))
    else $error("result changed while stalled");

  // the input side only waits on a held result
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with no output back-pressure");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a valid result carries fully known addresses
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({src_byte_addr, dst_byte_addr, out_last}))
    else $error("unknown bits in a valid result");

  // config writes are never blocked
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind strided_gather_address_generator sgag_checker u_sgag_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .src_byte_addr (out_ch.src_byte_addr),
  .dst_byte_addr (out_ch.dst_byte_addr),
  .out_last      (out_ch.last),
  .cfg_ready     (cfg_ch.ready)
);

`default_nettype wire
